// ----- design/ltbf_pkg.sv -----
// Shared types, codes and sizes for the line-terminator byte FIFO.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package ltbf_pkg;

    // Store depth and the widths that follow from it
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths fixed by the interface
    localparam int CMD_W  = 2;
    localparam int DATA_W = 8;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 9;
    localparam int TERM_W = 9;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL_REJ   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL_FLUSH = 2'd3;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TERM_1ST  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TERM_2ND  = 2'd2;

    // Configuration reset values
    localparam logic [CAP_W-1:0]  CAP_RESET    = 9'd256;
    localparam logic [DATA_W-1:0] TERM1_RESET  = 8'd13;
    localparam logic [DATA_W-1:0] TERM2_RESET  = 8'd10;

    // Commands from controller to datapath
    typedef struct packed {
        logic exec;   // item accepted: run the command on the queue
        logic load;   // finish the item and load the result register
    } ltbf_cmd_t;

endpackage
`default_nettype wire

// ----- design/line_terminator_byte_fifo.sv -----
// Line-terminator byte FIFO: usage notes
// Commands arrive on the s_ channel (valid/ready): s_command selects enqueue,
// dequeue, peek or flush, s_data_in carries the byte to enqueue. Each command
// yields exactly one result item on the m_ channel (valid/ready) with status,
// the byte read (zero if none), fill level, terminator count and a flag set
// when the fill level is at least half the capacity, rounded down.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 capacity, 1 and 2 the
// two terminator bytes) and cfg_data; cfg_ready is always high. Write only
// while no command is in flight.
// Timing: a command is taken in the idle state and the byte store is read on
// that edge; the result register loads in the finish state once it is free,
// as the byte store has a registered read port. No new command is taken until
// the last one has loaded; the next is taken while the result waits.
// Stall: if m_ready is low, the finished item waits in the controller until
// the result register frees, and s_ready stays low meanwhile.
// Reset (aresetn low, synchronous): queue empty, counts zero, capacity 256,
// terminators 13 and 10; store contents are not cleared.
// Depends on ltbf_pkg, ltbf_ctrl and ltbf_datapath.
`default_nettype none
module line_terminator_byte_fifo (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [ltbf_pkg::CIDX_W-1:0]  cfg_index,
    input  wire  [ltbf_pkg::CDAT_W-1:0]  cfg_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [ltbf_pkg::CMD_W-1:0]   s_command,
    input  wire  [ltbf_pkg::DATA_W-1:0]  s_data_in,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [ltbf_pkg::STAT_W-1:0]  m_status,
    output logic [ltbf_pkg::DATA_W-1:0]  m_data_out,
    output logic [ltbf_pkg::CNT_W-1:0]   m_fill_count,
    output logic [ltbf_pkg::TERM_W-1:0]  m_terminator_count,
    output logic                         m_above_watermark
);
    import ltbf_pkg::*;

    ltbf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Sequencer
    ltbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Queue storage and arithmetic
    ltbf_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_command          (s_command),
        .s_data_in          (s_data_in),
        .m_status           (m_status),
        .m_data_out         (m_data_out),
        .m_fill_count       (m_fill_count),
        .m_terminator_count (m_terminator_count),
        .m_above_watermark  (m_above_watermark)
    );

endmodule
`default_nettype wire

// ----- design/ltbf_ctrl.sv -----
// Controller for the line-terminator byte FIFO: two-state sequencer and
// result-valid flag. Depends on ltbf_pkg.
`default_nettype none
module ltbf_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire              m_ready,
    output ltbf_pkg::ltbf_cmd_t cmd
);
    import ltbf_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_FINISH = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    // Result register is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Sequence one item: run at accept, finish once the result slot frees
    always_comb begin
        state_next = state_reg;
        cmd.exec   = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/ltbf_datapath.sv -----
// Datapath for the line-terminator byte FIFO: configuration registers,
// byte store, slot pointers, counters and result register. Depends on ltbf_pkg.
`default_nettype none
module ltbf_datapath (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  ltbf_pkg::ltbf_cmd_t          cmd,
    input  wire                          cfg_valid,
    input  wire  [ltbf_pkg::CIDX_W-1:0]  cfg_index,
    input  wire  [ltbf_pkg::CDAT_W-1:0]  cfg_data,
    input  wire  [ltbf_pkg::CMD_W-1:0]   s_command,
    input  wire  [ltbf_pkg::DATA_W-1:0]  s_data_in,
    output logic [ltbf_pkg::STAT_W-1:0]  m_status,
    output logic [ltbf_pkg::DATA_W-1:0]  m_data_out,
    output logic [ltbf_pkg::CNT_W-1:0]   m_fill_count,
    output logic [ltbf_pkg::TERM_W-1:0]  m_terminator_count,
    output logic                         m_above_watermark
);
    import ltbf_pkg::*;

    // Configuration
    logic [CAP_W-1:0]  capacity_reg;
    logic [DATA_W-1:0] term1_reg;
    logic [DATA_W-1:0] term2_reg;

    // Byte store and its registered read port
    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Queue state
    logic [CNT_W-1:0]  wr_slot_reg, wr_slot_next;
    logic [CNT_W-1:0]  rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [TERM_W-1:0] term_cnt_reg, term_cnt_next;

    // Item context carried to the finish cycle
    logic [STAT_W-1:0] status_reg, status_next;
    logic              use_mem_reg, use_mem_next;
    logic              deq_reg, deq_next;

    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  wr_adv, rd_adv;
    logic [CNT_W:0]    wr_sum, rd_sum;
    logic              full, empty;
    logic              wr_en, rd_en;
    logic              din_is_term, dout_is_term;
    logic [TERM_W-1:0] term_fin;

    // Clamp capacity into 1..DEPTH
    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CNT_W'(capacity_reg) > CNT_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    // Advance slots, wrapping to zero at the capacity
    assign wr_sum = {1'b0, wr_slot_reg} + (CNT_W + 1)'(1);
    assign rd_sum = {1'b0, rd_slot_reg} + (CNT_W + 1)'(1);
    assign wr_adv = (wr_sum >= {1'b0, cap_eff}) ? '0 : wr_sum[CNT_W-1:0];
    assign rd_adv = (rd_sum >= {1'b0, cap_eff}) ? '0 : rd_sum[CNT_W-1:0];

    assign full        = (held_reg >= cap_eff);
    assign empty       = (held_reg == '0);
    assign din_is_term = (s_data_in == term1_reg) || (s_data_in == term2_reg);
    assign dout_is_term = (rd_data_reg == term1_reg) || (rd_data_reg == term2_reg);

    // Run the command against the queue state
    always_comb begin
        wr_slot_next  = wr_slot_reg;
        rd_slot_next  = rd_slot_reg;
        held_next     = held_reg;
        term_cnt_next = term_cnt_reg;
        status_next   = status_reg;
        use_mem_next  = use_mem_reg;
        deq_next      = deq_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        if (cmd.exec) begin
            status_next  = ST_OK;
            use_mem_next = 1'b0;
            deq_next     = 1'b0;
            case (s_command)
                CMD_ENQUEUE: begin
                    if (full) begin
                        if (term_cnt_reg != '0) begin
                            status_next = ST_FULL_REJ;
                        end else begin
                            status_next   = ST_FULL_FLUSH;
                            held_next     = '0;
                            term_cnt_next = '0;
                            wr_slot_next  = cap_eff;
                            rd_slot_next  = cap_eff;
                        end
                    end else begin
                        wr_en        = 1'b1;
                        wr_slot_next = wr_adv;
                        held_next    = held_reg + CNT_W'(1);
                        if (din_is_term && (term_cnt_reg != '1)) begin
                            term_cnt_next = term_cnt_reg + TERM_W'(1);
                        end
                    end
                end
                CMD_DEQUEUE: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        rd_en        = 1'b1;
                        use_mem_next = 1'b1;
                        deq_next     = 1'b1;
                        rd_slot_next = rd_adv;
                        held_next    = held_reg - CNT_W'(1);
                    end
                end
                CMD_PEEK: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        rd_en        = 1'b1;
                        use_mem_next = 1'b1;
                    end
                end
                CMD_FLUSH: begin
                    held_next     = '0;
                    term_cnt_next = '0;
                    wr_slot_next  = cap_eff;
                    rd_slot_next  = cap_eff;
                end
                default: ;
            endcase
        end else if (cmd.load) begin
            term_cnt_next = term_fin;
        end
    end

    // Drop the terminator count once the dequeued byte is known
    always_comb begin
        term_fin = term_cnt_reg;
        if (deq_reg && dout_is_term && (term_cnt_reg != '0)) begin
            term_fin = term_cnt_reg - TERM_W'(1);
        end
    end

    // Byte store: one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_adv[ADDR_W-1:0]] <= s_data_in;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_adv[ADDR_W-1:0]];
        end
    end

    // Configuration and queue state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            term1_reg    <= TERM1_RESET;
            term2_reg    <= TERM2_RESET;
            wr_slot_reg  <= CNT_W'(DEPTH);
            rd_slot_reg  <= CNT_W'(DEPTH);
            held_reg     <= '0;
            term_cnt_reg <= '0;
            status_reg   <= ST_OK;
            use_mem_reg  <= 1'b0;
            deq_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                    CFG_TERM_1ST: term1_reg    <= cfg_data[DATA_W-1:0];
                    CFG_TERM_2ND: term2_reg    <= cfg_data[DATA_W-1:0];
                    default: ;
                endcase
            end
            wr_slot_reg  <= wr_slot_next;
            rd_slot_reg  <= rd_slot_next;
            held_reg     <= held_next;
            term_cnt_reg <= term_cnt_next;
            status_reg   <= status_next;
            use_mem_reg  <= use_mem_next;
            deq_reg      <= deq_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_status           <= status_reg;
            m_data_out         <= use_mem_reg ? rd_data_reg : '0;
            m_fill_count       <= held_reg;
            m_terminator_count <= term_fin;
            m_above_watermark  <= (held_reg >= (cap_eff >> 1));
        end
    end

endmodule
`default_nettype wire
